// ----- rtl/wavhp_pkg.sv -----
`default_nettype none

package wavhp_pkg;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_INVALID     = 2'd1,
        STATUS_UNSUPPORTED = 2'd2
    } wavhp_status_t;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam int FMT_KEEP_BYTES = 16;

    // The first member sits in the highest bits, so the packed struct matches the
    // output tdata layout with status in the lowest bits.
    typedef struct packed {
        logic [31:0]   payload_size;
        logic [31:0]   payload_offset;
        logic [15:0]   frame_bytes;
        logic [5:0]    sample_bits;
        logic [31:0]   sample_rate;
        logic [15:0]   channel_count;
        wavhp_status_t status;
    } wavhp_result_t;

endpackage

`default_nettype wire

// ----- rtl/wavhp_fmt_check.sv -----
`default_nettype none

module wavhp_fmt_check (
    input  wire logic [127:0]            fmt_bytes,
    output wavhp_pkg::wavhp_status_t     verdict
);

    logic [15:0] coding;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [2:0]  bytes_per_sample;
    logic [18:0] frame;
    logic        bits_ok;

    assign coding           = fmt_bytes[15:0];
    assign channels         = fmt_bytes[31:16];
    assign rate             = fmt_bytes[63:32];
    assign align            = fmt_bytes[111:96];
    assign bits             = fmt_bytes[127:112];
    assign bytes_per_sample = bits[5:3];
    assign frame            = {3'd0, channels} * {16'd0, bytes_per_sample};
    assign bits_ok          = (bits != 16'd0) && (bits[2:0] == 3'd0) && (bits <= 16'd32);

    always_comb
    begin
        if (coding != 16'd1)
        begin
            verdict = wavhp_pkg::STATUS_UNSUPPORTED;
        end
        else if ((rate == 32'd0) || (channels == 16'd0) || !bits_ok)
        begin
            verdict = wavhp_pkg::STATUS_INVALID;
        end
        else if ((frame[18:16] != 3'd0) || (align != frame[15:0]))
        begin
            verdict = wavhp_pkg::STATUS_INVALID;
        end
        else
        begin
            verdict = wavhp_pkg::STATUS_OK;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wavhp_core.sv -----
`default_nettype none

module wavhp_core (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     step,
    input  wire logic [7:0]               byte_in,
    input  wire logic                     is_last,
    output logic                          res_valid,
    output wavhp_pkg::wavhp_result_t      res
);

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_HDR,
        PH_FMT,
        PH_SKIP,
        PH_FAIL,
        PH_DONE
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [31:0]              pos_reg, pos_next;
    logic [63:0]              shift_reg, shift_next;
    logic [2:0]               hdr_cnt_reg, hdr_cnt_next;
    logic [32:0]              left_reg, left_next;
    logic [127:0]             fmt_reg, fmt_next;
    logic [4:0]               fmt_cnt_reg, fmt_cnt_next;
    logic                     fmt_seen_reg, fmt_seen_next;
    logic                     data_seen_reg, data_seen_next;
    wavhp_pkg::wavhp_status_t verdict_reg, verdict_next;
    logic [31:0]              offset_reg, offset_next;
    logic [31:0]              size_reg, size_next;

    logic [127:0]             fmt_wr;
    wavhp_pkg::wavhp_status_t fmt_verdict;
    logic [63:0]              hdr_word;
    logic [31:0]              new_size;
    logic [32:0]              left_dec;
    logic [32:0]              left_skip;
    logic                     pad;
    logic                     emit_data;
    wavhp_pkg::wavhp_status_t end_status;
    wavhp_pkg::wavhp_result_t res_ok;

    always_comb
    begin
        fmt_wr = fmt_reg;
        if ((phase_reg == PH_FMT) && !fmt_cnt_reg[4])
        begin
            for (int i = 0; i < wavhp_pkg::FMT_KEEP_BYTES; i++)
            begin
                if (fmt_cnt_reg[3:0] == 4'(i))
                begin
                    fmt_wr[8*i +: 8] = byte_in;
                end
            end
        end
    end

    wavhp_fmt_check u_fmt_check (
        .fmt_bytes (fmt_wr),
        .verdict   (fmt_verdict)
    );

    assign hdr_word  = {byte_in, shift_reg[63:8]};
    assign new_size  = hdr_word[63:32];
    assign pad       = shift_reg[32];
    assign left_dec  = left_reg - 33'd1;
    assign left_skip = (left_reg != 33'd0) ? left_dec : left_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg + 32'd1;
        shift_next     = shift_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        left_next      = left_reg;
        fmt_next       = fmt_reg;
        fmt_cnt_next   = fmt_cnt_reg;
        fmt_seen_next  = fmt_seen_reg;
        data_seen_next = data_seen_reg;
        verdict_next   = verdict_reg;
        offset_next    = offset_reg;
        size_next      = size_reg;
        emit_data      = 1'b0;
        end_status     = wavhp_pkg::STATUS_INVALID;
        res_valid      = 1'b0;
        res            = '0;
        res_ok         = '0;

        case (phase_reg)
            PH_RIFF:
            begin
                shift_next = hdr_word;
                if ((pos_reg == 32'd3) && (hdr_word[63:32] != wavhp_pkg::TAG_RIFF))
                begin
                    verdict_next = wavhp_pkg::STATUS_INVALID;
                    phase_next   = PH_FAIL;
                end
                else if (pos_reg == 32'd11)
                begin
                    if (hdr_word[63:32] != wavhp_pkg::TAG_WAVE)
                    begin
                        verdict_next = wavhp_pkg::STATUS_INVALID;
                        phase_next   = PH_FAIL;
                    end
                    else
                    begin
                        phase_next   = PH_HDR;
                        hdr_cnt_next = 3'd0;
                    end
                end
            end
            PH_HDR:
            begin
                shift_next   = hdr_word;
                hdr_cnt_next = hdr_cnt_reg + 3'd1;
                if (hdr_cnt_reg == 3'd7)
                begin
                    left_next = {1'b0, new_size} + {32'd0, new_size[0]};
                    if (hdr_word[31:0] == wavhp_pkg::TAG_FMT)
                    begin
                        if (new_size < 32'd16)
                        begin
                            verdict_next = wavhp_pkg::STATUS_INVALID;
                            phase_next   = PH_FAIL;
                        end
                        else
                        begin
                            phase_next   = PH_FMT;
                            fmt_cnt_next = 5'd0;
                        end
                    end
                    else
                    begin
                        if (hdr_word[31:0] == wavhp_pkg::TAG_DATA)
                        begin
                            offset_next    = pos_reg + 32'd1;
                            size_next      = new_size;
                            data_seen_next = 1'b1;
                            emit_data      = fmt_seen_reg;
                        end
                        if (emit_data)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = (new_size == 32'd0) ? PH_HDR : PH_SKIP;
                        end
                    end
                end
            end
            PH_FMT:
            begin
                fmt_next  = fmt_wr;
                left_next = left_dec;
                if (!fmt_cnt_reg[4])
                begin
                    fmt_cnt_next = fmt_cnt_reg + 5'd1;
                end
                if (left_dec == {32'd0, pad})
                begin
                    if (fmt_verdict != wavhp_pkg::STATUS_OK)
                    begin
                        verdict_next = fmt_verdict;
                        phase_next   = PH_FAIL;
                    end
                    else
                    begin
                        fmt_seen_next = 1'b1;
                        phase_next    = pad ? PH_SKIP : PH_HDR;
                    end
                end
            end
            PH_SKIP:
            begin
                left_next = left_skip;
                if (left_skip == 33'd0)
                begin
                    phase_next = PH_HDR;
                end
            end
            default:
            begin
            end
        endcase

        res_ok.channel_count  = fmt_next[31:16];
        res_ok.sample_rate    = fmt_next[63:32];
        res_ok.sample_bits    = fmt_next[117:112];
        res_ok.frame_bytes    = fmt_next[111:96];
        res_ok.payload_offset = offset_next;
        res_ok.payload_size   = size_next;
        res_ok.status         = wavhp_pkg::STATUS_OK;

        if (emit_data)
        begin
            res_valid = 1'b1;
            res       = res_ok;
        end

        if (is_last)
        begin
            if (phase_next != PH_DONE)
            begin
                if (phase_next == PH_FAIL)
                begin
                    end_status = verdict_next;
                end
                else if ((phase_next == PH_RIFF) || (phase_next == PH_FMT))
                begin
                    end_status = wavhp_pkg::STATUS_INVALID;
                end
                else if (fmt_seen_next && data_seen_next)
                begin
                    end_status = wavhp_pkg::STATUS_OK;
                end
                else
                begin
                    end_status = wavhp_pkg::STATUS_INVALID;
                end
                res_valid = 1'b1;
                if (end_status == wavhp_pkg::STATUS_OK)
                begin
                    res = res_ok;
                end
                else
                begin
                    res        = '0;
                    res.status = end_status;
                end
            end
            phase_next     = PH_RIFF;
            pos_next       = 32'd0;
            hdr_cnt_next   = 3'd0;
            fmt_cnt_next   = 5'd0;
            fmt_seen_next  = 1'b0;
            data_seen_next = 1'b0;
            verdict_next   = wavhp_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RIFF;
            pos_reg       <= '0;
            shift_reg     <= '0;
            hdr_cnt_reg   <= '0;
            left_reg      <= '0;
            fmt_reg       <= '0;
            fmt_cnt_reg   <= '0;
            fmt_seen_reg  <= 1'b0;
            data_seen_reg <= 1'b0;
            verdict_reg   <= wavhp_pkg::STATUS_OK;
            offset_reg    <= '0;
            size_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            shift_reg     <= shift_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            left_reg      <= left_next;
            fmt_reg       <= fmt_next;
            fmt_cnt_reg   <= fmt_cnt_next;
            fmt_seen_reg  <= fmt_seen_next;
            data_seen_reg <= data_seen_next;
            verdict_reg   <= verdict_next;
            offset_reg    <= offset_next;
            size_reg      <= size_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wav_header_chunk_parser.sv -----
// Parses the header of a RIFF/WAVE (PCM) file that arrives one byte per item.
// The slave side takes one byte per item in s_tdata, with s_tlast on the final
// byte of the buffered file prefix. The master side gives at most one result
// item per prefix: status, channel count, sample rate, sample bits, frame bytes,
// payload offset and payload size. A result is sent as soon as a data chunk
// header completes after a good fmt chunk, and otherwise with the s_tlast byte.
// The s_tlast byte always returns the parser to its reset state, ready for the
// next prefix.
// An accepted byte is held in an input register and processed from there; a
// result that it produces is written to the output register, which drives
// m_tvalid. One byte can be accepted every cycle while no result is held back;
// the chunk walk state is updated once per processed byte.
// When the receiver stalls, the result waits in the output register. Bytes that
// produce no result keep flowing; a byte that would produce a second result
// waits in the input register until the output register is free.
// Reset clears all parser state and both registers, with no result pending.
`default_nettype none

module wav_header_chunk_parser (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // byte_in
    input  wire logic         s_tlast,   // is_last
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[1:0], channel_count[17:2], sample_rate[49:18], sample_bits[55:50],
    // frame_bytes[71:56], payload_offset[103:72], payload_size[135:104]
    output logic [135:0]      m_tdata
);

    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_last_reg;
    logic                     out_valid_reg;
    wavhp_pkg::wavhp_result_t out_res_reg;

    logic                     advance;
    logic                     res_valid;
    wavhp_pkg::wavhp_result_t res;

    assign advance  = in_valid_reg && (!res_valid || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

    wavhp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .byte_in   (in_byte_reg),
        .is_last   (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_byte_reg   <= '0;
            in_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                in_byte_reg  <= s_tdata;
                in_last_reg  <= s_tlast;
            end
            if (advance && res_valid)
            begin
                out_valid_reg <= 1'b1;
                out_res_reg   <= res;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
